### src/tpsd_pkg.sv
package tpsd_pkg;

    localparam logic [7:0] HDR_LAST_INDEX = 8'd17;
    localparam logic [7:0] RLE_IMAGE_TYPE = 8'd10;
    localparam logic [7:0] DEPTH_BITS_16  = 8'd16;
    localparam logic [7:0] DEPTH_BITS_24  = 8'd24;
    localparam logic [7:0] DEPTH_BITS_32  = 8'd32;
    localparam logic [7:0] RUN_FLAG_MIN   = 8'd128;
    localparam logic [7:0] RUN_BIAS       = 8'd127;

    typedef enum logic [1:0] {
        DEPTH_16,
        DEPTH_24,
        DEPTH_32
    } t_depth;

    // one decoded result as it leaves the parser, before color conversion
    typedef struct packed {
        logic [23:0] pixel_bytes;
        logic [7:0]  last_byte;
        t_depth      depth;
        logic [7:0]  repeat_count;
        logic        last_pixel;
        logic        format_error;
    } t_event;

endpackage

### src/tga_pixel_stream_decoder_top.sv
// TGA truecolor decoder, one file byte per transaction. The parser takes a byte in every
// cycle that push is high and full is low and emits at most one result per byte: an error
// result at header byte 17 for an unsupported depth, otherwise one result on the last byte
// of each pixel (RLE runs give one result with a repeat count). Results pass through a
// QUEUE_DEPTH-entry queue and a one-entry output register, so full rises only after
// QUEUE_DEPTH + 1 results wait unpopped; with pop held high the block sustains one byte
// per cycle while push is high. A byte with start_of_file high restarts parsing.
module tga_pixel_stream_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_alpha,
    output logic       o_has_alpha,
    output logic [7:0] o_repeat_count,
    output logic       o_last_pixel,
    output logic       o_format_error
);
    import tpsd_pkg::*;

    logic   w_accept;
    logic   w_ev_push;
    t_event w_ev;
    t_event w_q_data;
    logic   w_q_rd;
    logic   w_q_empty;
    logic   w_valid;

    assign w_accept = push && !full;
    assign empty    = !w_valid;

    tpsd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_ev_push       (w_ev_push),
        .o_ev            (w_ev)
    );

    tpsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_ev_push),
        .i_wr_data (w_ev),
        .i_rd      (w_q_rd),
        .o_rd_data (w_q_data),
        .o_full    (full),
        .o_empty   (w_q_empty)
    );

    tpsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_q_data       (w_q_data),
        .o_q_rd         (w_q_rd),
        .i_pop          (pop),
        .o_valid        (w_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_has_alpha    (o_has_alpha),
        .o_repeat_count (o_repeat_count),
        .o_last_pixel   (o_last_pixel),
        .o_format_error (o_format_error)
    );

endmodule

### src/tpsd_front.sv
module tpsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_start_of_file,
    output logic            o_ev_push,
    output tpsd_pkg::t_event o_ev
);
    import tpsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase, c_phase;
    logic [4:0]  r_header_index, n_header_index, c_header_index;
    logic [7:0]  r_id_skip_left, n_id_skip_left;
    logic        r_run_coded, n_run_coded;
    logic [15:0] r_image_width, n_image_width;
    logic [15:0] r_image_height, n_image_height;
    logic [7:0]  r_pixel_depth, n_pixel_depth;
    logic [31:0] r_pixels_left, n_pixels_left;
    logic [23:0] r_pixel_bytes, n_pixel_bytes;
    logic [1:0]  r_byte_in_pixel, n_byte_in_pixel;
    logic [7:0]  r_packet_left, n_packet_left;
    logic        r_packet_is_run, n_packet_is_run;

    logic [31:0] w_area;
    logic        w_depth_ok;
    logic [2:0]  w_nbytes;
    t_depth      w_depth;
    logic [7:0]  w_id_next;
    logic [7:0]  w_rep;
    logic [31:0] w_pixels_after;
    logic [7:0]  w_packet_after;

    assign w_area     = r_image_width * r_image_height;
    assign w_depth_ok = (r_pixel_depth == DEPTH_BITS_24) || (r_pixel_depth == DEPTH_BITS_32) ||
                        ((r_pixel_depth == DEPTH_BITS_16) && !r_run_coded);
    assign w_nbytes   = r_pixel_depth[5:3];
    assign w_depth    = (r_pixel_depth == DEPTH_BITS_16) ? DEPTH_16 :
                        (r_pixel_depth == DEPTH_BITS_24) ? DEPTH_24 : DEPTH_32;
    assign w_id_next  = (r_id_skip_left != 8'd0) ? r_id_skip_left - 8'd1 : r_id_skip_left;

    always_comb begin
        if (r_run_coded && r_packet_is_run) begin
            w_rep          = (r_pixels_left < {24'd0, r_packet_left}) ?
                             r_pixels_left[7:0] : r_packet_left;
            w_packet_after = 8'd0;
        end else begin
            w_rep          = 8'd1;
            w_packet_after = (r_run_coded && r_packet_left != 8'd0) ?
                             r_packet_left - 8'd1 : r_packet_left;
        end
        w_pixels_after = r_pixels_left - {24'd0, w_rep};
    end

    always_comb begin
        n_phase         = r_phase;
        n_header_index  = r_header_index;
        n_id_skip_left  = r_id_skip_left;
        n_run_coded     = r_run_coded;
        n_image_width   = r_image_width;
        n_image_height  = r_image_height;
        n_pixel_depth   = r_pixel_depth;
        n_pixels_left   = r_pixels_left;
        n_pixel_bytes   = r_pixel_bytes;
        n_byte_in_pixel = r_byte_in_pixel;
        n_packet_left   = r_packet_left;
        n_packet_is_run = r_packet_is_run;
        o_ev_push       = 1'b0;
        o_ev            = '0;
        c_phase         = i_start_of_file ? PH_HEADER : r_phase;
        c_header_index  = i_start_of_file ? 5'd0 : r_header_index;

        if (i_accept) begin
            unique case (c_phase)
                PH_HEADER: begin
                    n_phase = PH_HEADER;
                    case (c_header_index)
                        5'd0:  n_id_skip_left = i_data_byte;
                        5'd2:  n_run_coded = (i_data_byte == RLE_IMAGE_TYPE);
                        5'd12: n_image_width[7:0] = i_data_byte;
                        5'd13: n_image_width[15:8] = i_data_byte;
                        5'd14: n_image_height[7:0] = i_data_byte;
                        5'd15: n_image_height[15:8] = i_data_byte;
                        5'd16: n_pixel_depth = i_data_byte;
                        default: ;
                    endcase
                    if ({3'd0, c_header_index} >= HDR_LAST_INDEX) begin
                        n_header_index = 5'd0;
                        if (!w_depth_ok) begin
                            o_ev_push         = 1'b1;
                            o_ev.format_error = 1'b1;
                            n_phase           = PH_DONE;
                        end else begin
                            n_pixels_left   = w_area;
                            n_pixel_bytes   = 24'd0;
                            n_byte_in_pixel = 2'd0;
                            n_packet_left   = 8'd0;
                            n_packet_is_run = 1'b0;
                            if (r_id_skip_left != 8'd0) begin
                                n_phase = PH_IDSKIP;
                            end else if (w_area == 32'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = r_run_coded ? PH_PACKET : PH_PIXEL;
                            end
                        end
                    end else begin
                        n_header_index = c_header_index + 5'd1;
                    end
                end
                PH_IDSKIP: begin
                    n_id_skip_left = w_id_next;
                    if (w_id_next == 8'd0) begin
                        if (r_pixels_left == 32'd0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = r_run_coded ? PH_PACKET : PH_PIXEL;
                        end
                    end
                end
                PH_PACKET: begin
                    if (i_data_byte < RUN_FLAG_MIN) begin
                        n_packet_is_run = 1'b0;
                        n_packet_left   = i_data_byte + 8'd1;
                    end else begin
                        n_packet_is_run = 1'b1;
                        n_packet_left   = i_data_byte - RUN_BIAS;
                    end
                    n_pixel_bytes   = 24'd0;
                    n_byte_in_pixel = 2'd0;
                    n_phase         = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if ({1'b0, r_byte_in_pixel} + 3'd1 < w_nbytes) begin
                        case (r_byte_in_pixel)
                            2'd0:    n_pixel_bytes[7:0]   = i_data_byte;
                            2'd1:    n_pixel_bytes[15:8]  = i_data_byte;
                            2'd2:    n_pixel_bytes[23:16] = i_data_byte;
                            default: ;
                        endcase
                        n_byte_in_pixel = r_byte_in_pixel + 2'd1;
                    end else begin
                        o_ev_push         = 1'b1;
                        o_ev.pixel_bytes  = r_pixel_bytes;
                        o_ev.last_byte    = i_data_byte;
                        o_ev.depth        = w_depth;
                        o_ev.repeat_count = w_rep;
                        o_ev.last_pixel   = (w_pixels_after == 32'd0);
                        n_pixel_bytes     = 24'd0;
                        n_byte_in_pixel   = 2'd0;
                        n_packet_left     = w_packet_after;
                        n_pixels_left     = w_pixels_after;
                        if (w_pixels_after == 32'd0) begin
                            n_phase = PH_DONE;
                        end else if (r_run_coded && w_packet_after == 8'd0) begin
                            n_phase = PH_PACKET;
                        end
                    end
                end
                PH_DONE: ;
                default: n_phase = PH_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HEADER;
            r_header_index  <= 5'd0;
            r_id_skip_left  <= 8'd0;
            r_run_coded     <= 1'b0;
            r_image_width   <= 16'd0;
            r_image_height  <= 16'd0;
            r_pixel_depth   <= 8'd0;
            r_pixels_left   <= 32'd0;
            r_pixel_bytes   <= 24'd0;
            r_byte_in_pixel <= 2'd0;
            r_packet_left   <= 8'd0;
            r_packet_is_run <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_header_index  <= n_header_index;
            r_id_skip_left  <= n_id_skip_left;
            r_run_coded     <= n_run_coded;
            r_image_width   <= n_image_width;
            r_image_height  <= n_image_height;
            r_pixel_depth   <= n_pixel_depth;
            r_pixels_left   <= n_pixels_left;
            r_pixel_bytes   <= n_pixel_bytes;
            r_byte_in_pixel <= n_byte_in_pixel;
            r_packet_left   <= n_packet_left;
            r_packet_is_run <= n_packet_is_run;
        end
    end

    a_last_ends_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_push && o_ev.last_pixel |=> r_phase == PH_DONE)
        else $error("last pixel did not end the image");

    a_rep_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_push && !o_ev.format_error |-> o_ev.repeat_count != 8'd0)
        else $error("pixel transaction with zero repeat count");

    a_idskip_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDSKIP |-> r_id_skip_left != 8'd0)
        else $error("id skip phase with nothing left to skip");

endmodule

### src/tpsd_queue.sv
module tpsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  tpsd_pkg::t_event i_wr_data,
    input  logic             i_rd,
    output tpsd_pkg::t_event o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    import tpsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr, w_rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr && !o_full;
    assign w_rd      = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### src/tpsd_back.sv
module tpsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  tpsd_pkg::t_event i_q_data,
    output logic             o_q_rd,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic             o_has_alpha,
    output logic [7:0]       o_repeat_count,
    output logic             o_last_pixel,
    output logic             o_format_error
);
    import tpsd_pkg::*;

    logic        r_valid;
    logic [7:0]  n_red, n_green, n_blue, n_alpha;
    logic        n_has_alpha;
    logic [15:0] w_word;

    assign o_valid = r_valid;
    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign w_word  = {i_q_data.last_byte, i_q_data.pixel_bytes[7:0]};

    always_comb begin
        n_red       = 8'd0;
        n_green     = 8'd0;
        n_blue      = 8'd0;
        n_alpha     = 8'd0;
        n_has_alpha = 1'b0;
        if (!i_q_data.format_error) begin
            unique case (i_q_data.depth)
                DEPTH_16: begin
                    n_blue  = {w_word[4:0], 3'd0};
                    n_green = {w_word[9:5], 3'd0};
                    n_red   = {w_word[14:10], 3'd0};
                end
                DEPTH_24: begin
                    n_blue  = i_q_data.pixel_bytes[7:0];
                    n_green = i_q_data.pixel_bytes[15:8];
                    n_red   = i_q_data.last_byte;
                end
                DEPTH_32: begin
                    n_blue      = i_q_data.pixel_bytes[7:0];
                    n_green     = i_q_data.pixel_bytes[15:8];
                    n_red       = i_q_data.pixel_bytes[23:16];
                    n_alpha     = i_q_data.last_byte;
                    n_has_alpha = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            o_red          <= n_red;
            o_green        <= n_green;
            o_blue         <= n_blue;
            o_alpha        <= n_alpha;
            o_has_alpha    <= n_has_alpha;
            o_repeat_count <= i_q_data.repeat_count;
            o_last_pixel   <= i_q_data.last_pixel;
            o_format_error <= i_q_data.format_error;
        end
    end

endmodule
